FILE: hdl/hrl_pkg.sv
// Shared types, codes and helpers for the hex record loader.
`default_nettype none
package hrl_pkg;

   localparam int ADDR_WIDTH = 16;
   localparam logic [15:0] ADDR_MASK = 16'(((64'(1)) << ADDR_WIDTH) - 64'(1));

   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_UA    = 8'h41;
   localparam logic [7:0] CHAR_UF    = 8'h46;
   localparam logic [7:0] CHAR_LA    = 8'h61;
   localparam logic [7:0] CHAR_LF_HEX = 8'h66;

   localparam logic [7:0] REC_DATA  = 8'h00;
   localparam logic [7:0] REC_EOF   = 8'h01;
   localparam logic [7:0] REC_START = 8'h03;
   localparam logic [7:0] START_REC_LEN = 8'h04;

   localparam logic [2:0] KIND_WRITE     = 3'd0;
   localparam logic [2:0] KIND_START     = 3'd1;
   localparam logic [2:0] KIND_END_OK    = 3'd2;
   localparam logic [2:0] KIND_BAD_CHAR  = 3'd3;
   localparam logic [2:0] KIND_BAD_LEN   = 3'd4;
   localparam logic [2:0] KIND_EARLY_END = 3'd5;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] target_address;
      logic [15:0] payload;
      logic        last_of_run;
   } result_type;

   // Results of one character: zero, one or two beats.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } step_out_type;

   // Bit 4 flags a character that is not a hex digit.
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'h10;
      if (c inside {[CHAR_0:CHAR_9]}) begin
         r = {1'b0, 4'(c - CHAR_0)};
      end else if (c inside {[CHAR_UA:CHAR_UF]}) begin
         r = {1'b0, 4'(c - CHAR_UA + 8'd10)};
      end else if (c inside {[CHAR_LA:CHAR_LF_HEX]}) begin
         r = {1'b0, 4'(c - CHAR_LA + 8'd10)};
      end
      return r;
   endfunction

   function automatic result_type make_result(input logic [2:0] kind,
                                              input logic [15:0] addr,
                                              input logic [15:0] data);
      result_type r;
      r.kind = kind;
      r.target_address = addr;
      r.payload = data;
      r.last_of_run = 1'b0;
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/hrl_parser.sv
// Record parser: parse state registers and the per-character update logic.
`default_nettype none
module hrl_parser (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  fire,
   input  wire logic [7:0]            character,
   input  wire logic                  end_of_text,
   output hrl_pkg::step_out_type      step_out
);

   typedef enum logic [6:0] {
      PH_START = 7'b0000001,
      PH_COUNT = 7'b0000010,
      PH_ADDR  = 7'b0000100,
      PH_TYPE  = 7'b0001000,
      PH_DATA  = 7'b0010000,
      PH_WORD  = 7'b0100000,
      PH_CHECK = 7'b1000000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [1:0]  digit_count_ff, digit_count_in;
   logic [15:0] field_value_ff, field_value_in;
   logic [7:0]  record_length_ff, record_length_in;
   logic [7:0]  bytes_left_ff, bytes_left_in;
   logic [15:0] load_address_ff, load_address_in;
   logic        words_taken_ff, words_taken_in;
   logic        finished_ff, finished_in;

   always_comb begin
      logic [4:0]  hex;
      logic [15:0] val;
      logic        done;
      logic [7:0]  left;
      hrl_pkg::result_type r0;
      hrl_pkg::result_type r1;
      logic [1:0]  n;

      phase_in         = phase_ff;
      digit_count_in   = digit_count_ff;
      field_value_in   = field_value_ff;
      record_length_in = record_length_ff;
      bytes_left_in    = bytes_left_ff;
      load_address_in  = load_address_ff;
      words_taken_in   = words_taken_ff;
      finished_in      = finished_ff;
      hex  = hrl_pkg::hex_decode(character);
      val  = {field_value_ff[11:0], hex[3:0]};
      left = bytes_left_ff - 8'd1;
      done = 1'b0;
      r0 = hrl_pkg::make_result(hrl_pkg::KIND_WRITE, 16'h0, 16'h0);
      r1 = r0;
      n  = 2'd0;

      if (!finished_ff) begin
         if (phase_ff == PH_START) begin
            if (character == hrl_pkg::CHAR_LF || character == hrl_pkg::CHAR_CR) begin
               phase_in = PH_START;
            end else if (character != hrl_pkg::CHAR_COLON) begin
               r0 = hrl_pkg::make_result(hrl_pkg::KIND_BAD_CHAR, 16'h0, 16'h0);
               n = 2'd1;
               finished_in = 1'b1;
            end else begin
               phase_in = PH_COUNT;
               digit_count_in = 2'd0;
               field_value_in = 16'h0;
            end
         end else if (hex[4]) begin
            r0 = hrl_pkg::make_result(hrl_pkg::KIND_BAD_CHAR, 16'h0, 16'h0);
            n = 2'd1;
            finished_in = 1'b1;
         end else begin
            field_value_in = val;
            if (phase_ff == PH_ADDR || phase_ff == PH_WORD) begin
               done = (digit_count_ff == 2'd3);
            end else begin
               done = (digit_count_ff != 2'd0);
            end
            if (!done) begin
               digit_count_in = digit_count_ff + 2'd1;
            end else begin
               digit_count_in = 2'd0;
               field_value_in = 16'h0;
               case (phase_ff)
                  PH_COUNT: begin
                     record_length_in = val[7:0];
                     bytes_left_in = val[7:0];
                     phase_in = PH_ADDR;
                  end
                  PH_ADDR: begin
                     load_address_in = val & hrl_pkg::ADDR_MASK;
                     phase_in = PH_TYPE;
                  end
                  PH_TYPE: begin
                     if (val[7:0] == hrl_pkg::REC_DATA) begin
                        phase_in = (bytes_left_ff == 8'd0) ? PH_CHECK : PH_DATA;
                     end else if (val[7:0] == hrl_pkg::REC_START) begin
                        if (record_length_ff != hrl_pkg::START_REC_LEN) begin
                           r0 = hrl_pkg::make_result(hrl_pkg::KIND_BAD_LEN, 16'h0, 16'h0);
                           n = 2'd1;
                           finished_in = 1'b1;
                        end else begin
                           words_taken_in = 1'b0;
                           phase_in = PH_WORD;
                        end
                     end else if (val[7:0] == hrl_pkg::REC_EOF) begin
                        r0 = hrl_pkg::make_result(hrl_pkg::KIND_END_OK, 16'h0, 16'h0);
                        n = 2'd1;
                        finished_in = 1'b1;
                     end else begin
                        phase_in = PH_CHECK;
                     end
                  end
                  PH_DATA: begin
                     r0 = hrl_pkg::make_result(hrl_pkg::KIND_WRITE, load_address_ff,
                                               {8'h00, val[7:0]});
                     n = 2'd1;
                     load_address_in = (load_address_ff + 16'd1) & hrl_pkg::ADDR_MASK;
                     bytes_left_in = left;
                     if (left == 8'd0) begin
                        phase_in = PH_CHECK;
                     end
                  end
                  PH_WORD: begin
                     if (!words_taken_ff) begin
                        words_taken_in = 1'b1;
                     end else begin
                        r0 = hrl_pkg::make_result(hrl_pkg::KIND_START, 16'h0, val);
                        n = 2'd1;
                        phase_in = PH_CHECK;
                     end
                  end
                  default: begin
                     phase_in = PH_START;
                  end
               endcase
            end
         end
      end

      // End of text closes the image; the state goes back to its reset value.
      if (end_of_text) begin
         if (!finished_in) begin
            if (n == 2'd0) begin
               r0 = hrl_pkg::make_result(hrl_pkg::KIND_EARLY_END, 16'h0, 16'h0);
            end else begin
               r1 = hrl_pkg::make_result(hrl_pkg::KIND_EARLY_END, 16'h0, 16'h0);
            end
            n = n + 2'd1;
         end
         phase_in         = PH_START;
         digit_count_in   = 2'd0;
         field_value_in   = 16'h0;
         record_length_in = 8'h0;
         bytes_left_in    = 8'h0;
         load_address_in  = 16'h0;
         words_taken_in   = 1'b0;
         finished_in      = 1'b0;
      end

      if (n == 2'd2) begin
         r1.last_of_run = 1'b1;
      end else begin
         r0.last_of_run = 1'b1;
      end
      step_out.count  = n;
      step_out.first  = r0;
      step_out.second = r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_START;
         digit_count_ff   <= 2'd0;
         field_value_ff   <= 16'h0;
         record_length_ff <= 8'h0;
         bytes_left_ff    <= 8'h0;
         load_address_ff  <= 16'h0;
         words_taken_ff   <= 1'b0;
         finished_ff      <= 1'b0;
      end else if (fire) begin
         phase_ff         <= phase_in;
         digit_count_ff   <= digit_count_in;
         field_value_ff   <= field_value_in;
         record_length_ff <= record_length_in;
         bytes_left_ff    <= bytes_left_in;
         load_address_ff  <= load_address_in;
         words_taken_ff   <= words_taken_in;
         finished_ff      <= finished_in;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/hrl_rsp_queue.sv
// Result queue: four entries, takes up to two beats per cycle, sends one per cycle while rsp_stall is low.
`default_nettype none
module hrl_rsp_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire hrl_pkg::step_out_type step_out,
   output logic                       room,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output hrl_pkg::result_type        head
);

   hrl_pkg::result_type entries[4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic [1:0] push_n;
   logic       pop;

   assign push_n    = push ? step_out.count : 2'd0;
   assign rsp_valid = (count_ff != 3'd0);
   assign pop       = rsp_valid && !rsp_stall;
   // Room for the worst case of two beats from one character.
   assign room      = (count_ff <= 3'd2);
   assign head      = entries[rd_ptr_ff];

   assign wr_ptr_in = wr_ptr_ff + push_n;
   assign rd_ptr_in = rd_ptr_ff + {1'b0, pop};
   assign count_in  = count_ff + {1'b0, push_n} - {2'b00, pop};

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         entries[wr_ptr_ff] <= step_out.first;
      end
      if (push_n == 2'd2) begin
         entries[wr_ptr_ff + 2'd1] <= step_out.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/hex_record_loader.sv
// A character accepted into the input register is parsed when it fires, and its results
// are written into the result queue, which offers them. Throughput: one character per
// cycle while the queue has room; a character that yields two results sends them in turn,
// and the four-entry result queue absorbs the difference. The input register advances only
// while the queue has room for two beats. Reset (synchronous, active high) empties the
// queue and returns the parser to waiting for a record start.
`default_nettype none
module hex_record_loader (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_character,
   input  wire logic        req_end_of_text,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_kind,
   output logic [15:0]      rsp_target_address,
   output logic [15:0]      rsp_payload,
   output logic             rsp_last_of_run
);

   logic       stage_valid_ff, stage_valid_in;
   logic [7:0] stage_char_ff, stage_char_in;
   logic       stage_eot_ff, stage_eot_in;
   logic       room;
   logic       fire;
   logic       accept;
   hrl_pkg::step_out_type step_out;
   hrl_pkg::result_type   head;

   assign fire      = stage_valid_ff && room;
   assign req_stall = stage_valid_ff && !room;
   assign accept    = req_valid && !req_stall;

   assign stage_valid_in = accept || (stage_valid_ff && !fire);
   assign stage_char_in  = accept ? req_character : stage_char_ff;
   assign stage_eot_in   = accept ? req_end_of_text : stage_eot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_char_ff <= stage_char_in;
      stage_eot_ff  <= stage_eot_in;
   end

   hrl_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .character   (stage_char_ff),
      .end_of_text (stage_eot_ff),
      .step_out    (step_out)
   );

   hrl_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fire),
      .step_out  (step_out),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head      (head)
   );

   assign rsp_kind           = head.kind;
   assign rsp_target_address = head.target_address;
   assign rsp_payload        = head.payload;
   assign rsp_last_of_run    = head.last_of_run;

endmodule
`default_nettype wire
